// ===== hw/rtl/absl_pkg.sv =====
// ----------------------------------------------------------------------------
// Alternating-bit serial link package
// Shared widths, codes and constants of the serial link endpoint.
// ----------------------------------------------------------------------------
package absl_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  localparam logic [1:0] OP_LINE = 2'd0;
  localparam logic [1:0] OP_APP  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_LINE    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_EVENT   = 2'd2;

  localparam logic [7:0] EVT_BUSY     = 8'd0;
  localparam logic [7:0] EVT_CRC_BAD  = 8'd1;
  localparam logic [7:0] EVT_TIMEOUT  = 8'd2;
  localparam logic [7:0] EVT_BAD_LEN  = 8'd3;
  localparam logic [7:0] EVT_ACK      = 8'd4;
  localparam logic [7:0] EVT_OVERFLOW = 8'd5;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_PUBLISH = 2'd1;
  localparam logic [1:0] REG_ACK     = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [6:0]  PUBLISH_RST = 7'd3;
  localparam logic [6:0]  ACK_RST     = 7'd4;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [7:0] FRAME_OVERHEAD = 8'd5;

endpackage

// ===== hw/rtl/absl_if.sv =====
// ----------------------------------------------------------------------------
// Alternating-bit serial link channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface absl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, opcode, data_byte, end_of_message, input ready);
  modport sink (input valid, opcode, data_byte, end_of_message, output ready);
endinterface

interface absl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, kind, value, last, input ready);
  modport sink (input valid, kind, value, last, output ready);
endinterface

// ===== hw/rtl/alternating_bit_serial_link.sv =====
// ----------------------------------------------------------------------------
// Alternating-bit serial link endpoint
// Frames application messages as PUBLISH with CRC-32, checks received frames,
// delivers payload, answers with ACK frames and reports events.
// ----------------------------------------------------------------------------
//  channel    dir  fields
//  in_beat    in   opcode, data_byte, end_of_message
//  out_beat   out  kind, value, last
//  cfg_*      in   cfg_we, cfg_index, cfg_data
//
//  A received line byte inside the CRC span is folded into the CRC in S_RXCRC; any
//  other item is taken in S_IDLE, going on to S_EVT when it raises an event.
//  Sent bytes leave in S_TXBYTE, all but CRC bytes then pass S_TXCRC; payload is read
//  in S_TXRD, delivered payload in S_DLV_RD before it is sent in S_DLV_OUT.
//  Reset is synchronous; no clearing pass is needed.
//  A stalled output beat holds the sequencer; input is taken only when idle.
module alternating_bit_serial_link #(
  parameter int MAX_PAYLOAD = absl_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  absl_in_if.sink     in_beat,
  absl_out_if.source  out_beat,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int FRAME_MAX = MAX_PAYLOAD + 6;
  localparam int CW  = $clog2(FRAME_MAX + 1);
  localparam int AW  = $clog2(FRAME_MAX);
  localparam int TAW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int TCW = $clog2(MAX_PAYLOAD + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RXCRC   = 4'd1;
  localparam logic [3:0] S_FIN     = 4'd2;
  localparam logic [3:0] S_EVT     = 4'd3;
  localparam logic [3:0] S_DLV_RD  = 4'd4;
  localparam logic [3:0] S_DLV_OUT = 4'd5;
  localparam logic [3:0] S_TXBYTE  = 4'd6;
  localparam logic [3:0] S_TXCRC   = 4'd7;
  localparam logic [3:0] S_TXRD    = 4'd8;

  localparam logic [1:0] PH_LEN = 2'd0;
  localparam logic [1:0] PH_CMD = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;
  localparam logic [1:0] PH_CRC = 2'd3;

  logic [15:0] timeout_ticks;
  logic [6:0]  publish_code;
  logic [6:0]  ack_code;

  logic [3:0]  state;
  logic [2:0]  bit_cnt;
  logic [7:0]  evt;

  logic [7:0]  rx_mem [FRAME_MAX];
  logic [7:0]  rx_rd_data;
  logic [CW-1:0] rx_count;
  logic [AW-1:0] rx_ptr;
  logic [7:0]  rx_len;
  logic [7:0]  rx_cmd;
  logic [31:0] rx_got;
  logic [31:0] rx_crc;
  logic        rx_fin;
  logic [15:0] idle_cnt;
  logic        exp_bit;

  logic [7:0]  tx_mem [MAX_PAYLOAD];
  logic [7:0]  tx_rd_data;
  logic [TCW-1:0] tx_count;
  logic [TCW-1:0] tx_plen;
  logic [TAW-1:0] tx_ptr;
  logic [7:0]  tx_cmd;
  logic [31:0] tx_crc;
  logic [1:0]  tx_phase;
  logic [1:0]  crc_idx;
  logic        tx_seq;
  logic        awaiting_ack;

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic        out_last;

  logic        accept;
  logic        slot_free;
  logic        out_load;
  logic [31:0] crc_in;
  logic [31:0] crc_step;
  logic [31:0] tx_crc_fin;
  logic [7:0]  tx_byte;
  logic [7:0]  len_eff;
  logic [15:0] idle_next;
  logic        rx_we;
  logic        tx_we;

  assign in_beat.ready  = (state == S_IDLE);
  assign accept         = in_beat.valid && in_beat.ready;
  assign slot_free      = !out_valid || out_beat.ready;
  assign out_load       = slot_free &&
                          ((state == S_EVT) || (state == S_DLV_OUT) || (state == S_TXBYTE));
  assign out_beat.valid = out_valid;
  assign out_beat.kind  = out_kind;
  assign out_beat.value = out_value;
  assign out_beat.last  = out_last;

  assign crc_in     = (state == S_TXCRC) ? tx_crc : rx_crc;
  assign crc_step   = {1'b0, crc_in[31:1]} ^ (crc_in[0] ? absl_pkg::CRC_POLY : 32'd0);
  assign tx_crc_fin = ~tx_crc;
  assign len_eff    = (rx_count == '0) ? in_beat.data_byte : rx_len;
  assign idle_next  = idle_cnt + 16'd1;

  always_comb begin
    case (tx_phase)
      PH_LEN:  tx_byte = 8'(tx_plen) + absl_pkg::FRAME_OVERHEAD;
      PH_CMD:  tx_byte = tx_cmd;
      PH_PAY:  tx_byte = tx_rd_data;
      default: tx_byte = tx_crc_fin[8*crc_idx +: 8];
    endcase
  end

  assign rx_we = accept && (in_beat.opcode == absl_pkg::OP_LINE) &&
                 !((rx_count == '0) && ((in_beat.data_byte < absl_pkg::FRAME_OVERHEAD) ||
                   (in_beat.data_byte > 8'(MAX_PAYLOAD + 5))));
  assign tx_we = accept && (in_beat.opcode == absl_pkg::OP_APP) && !awaiting_ack &&
                 (tx_count < TCW'(MAX_PAYLOAD));

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_count[AW-1:0]] <= in_beat.data_byte;
    end
    rx_rd_data <= rx_mem[rx_ptr];
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_count[TAW-1:0]] <= in_beat.data_byte;
    end
    tx_rd_data <= tx_mem[tx_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= absl_pkg::TIMEOUT_RST;
      publish_code  <= absl_pkg::PUBLISH_RST;
      ack_code      <= absl_pkg::ACK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        absl_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data;
        absl_pkg::REG_PUBLISH: publish_code  <= cfg_data[6:0];
        absl_pkg::REG_ACK:     ack_code      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bit_cnt      <= '0;
      rx_count     <= '0;
      rx_crc       <= absl_pkg::CRC_INIT;
      idle_cnt     <= '0;
      exp_bit      <= 1'b0;
      tx_count     <= '0;
      tx_seq       <= 1'b0;
      awaiting_ack <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_beat.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_beat.opcode)
              absl_pkg::OP_LINE: begin
                idle_cnt <= '0;
                if (!rx_we) begin
                  rx_count <= '0;
                  rx_crc   <= absl_pkg::CRC_INIT;
                  evt      <= absl_pkg::EVT_BAD_LEN;
                  state    <= S_EVT;
                end else begin
                  rx_len   <= len_eff;
                  if (rx_count == CW'(1)) begin
                    rx_cmd <= in_beat.data_byte;
                  end
                  rx_got   <= {in_beat.data_byte, rx_got[31:8]};
                  rx_count <= rx_count + CW'(1);
                  rx_fin   <= (8'(rx_count) == len_eff);
                  if (8'(rx_count) + 8'd3 < len_eff) begin
                    rx_crc <= ((rx_count == '0) ? absl_pkg::CRC_INIT : rx_crc) ^
                              {24'd0, in_beat.data_byte};
                    state  <= S_RXCRC;
                  end else begin
                    if (rx_count == '0) begin
                      rx_crc <= absl_pkg::CRC_INIT;
                    end
                    state <= (8'(rx_count) == len_eff) ? S_FIN : S_IDLE;
                  end
                end
              end
              absl_pkg::OP_APP: begin
                if (awaiting_ack) begin
                  evt   <= absl_pkg::EVT_BUSY;
                  state <= S_EVT;
                end else if (!tx_we) begin
                  tx_count <= '0;
                  evt      <= absl_pkg::EVT_OVERFLOW;
                  state    <= S_EVT;
                end else if (in_beat.end_of_message) begin
                  tx_plen      <= tx_count + TCW'(1);
                  tx_count     <= '0;
                  awaiting_ack <= 1'b1;
                  tx_cmd       <= {tx_seq, publish_code};
                  tx_crc       <= absl_pkg::CRC_INIT;
                  tx_phase     <= PH_LEN;
                  crc_idx      <= '0;
                  state        <= S_TXBYTE;
                end else begin
                  tx_count <= tx_count + TCW'(1);
                end
              end
              absl_pkg::OP_TICK: begin
                if (rx_count != '0) begin
                  if ((idle_next >= timeout_ticks) || (idle_next == '0)) begin
                    rx_count <= '0;
                    rx_crc   <= absl_pkg::CRC_INIT;
                    idle_cnt <= '0;
                    evt      <= absl_pkg::EVT_TIMEOUT;
                    state    <= S_EVT;
                  end else begin
                    idle_cnt <= idle_next;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_RXCRC: begin
          rx_crc  <= crc_step;
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= rx_fin ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          rx_count <= '0;
          rx_crc   <= absl_pkg::CRC_INIT;
          idle_cnt <= '0;
          if (rx_got != ~rx_crc) begin
            evt   <= absl_pkg::EVT_CRC_BAD;
            state <= S_EVT;
          end else if (rx_cmd[6:0] == publish_code) begin
            if ((rx_cmd[7] == exp_bit) && (rx_len != absl_pkg::FRAME_OVERHEAD)) begin
              exp_bit <= ~exp_bit;
              rx_ptr  <= AW'(2);
              state   <= S_DLV_RD;
            end else begin
              if (rx_cmd[7] == exp_bit) begin
                exp_bit <= ~exp_bit;
              end
              tx_plen  <= '0;
              tx_cmd   <= {rx_cmd[7], ack_code};
              tx_crc   <= absl_pkg::CRC_INIT;
              tx_phase <= PH_LEN;
              crc_idx  <= '0;
              state    <= S_TXBYTE;
            end
          end else if ((rx_cmd[6:0] == ack_code) && (rx_cmd[7] == tx_seq)) begin
            tx_seq       <= ~tx_seq;
            awaiting_ack <= 1'b0;
            evt          <= absl_pkg::EVT_ACK;
            state        <= S_EVT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EVT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= absl_pkg::KIND_EVENT;
            out_value <= evt;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DLV_RD: begin
          state <= S_DLV_OUT;
        end
        S_DLV_OUT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= absl_pkg::KIND_PAYLOAD;
            out_value <= rx_rd_data;
            out_last  <= 1'b0;
            if (8'(rx_ptr) == rx_len - 8'd4) begin
              tx_plen  <= '0;
              tx_cmd   <= {rx_cmd[7], ack_code};
              tx_crc   <= absl_pkg::CRC_INIT;
              tx_phase <= PH_LEN;
              crc_idx  <= '0;
              state    <= S_TXBYTE;
            end else begin
              rx_ptr <= rx_ptr + AW'(1);
              state  <= S_DLV_RD;
            end
          end
        end
        S_TXBYTE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= absl_pkg::KIND_LINE;
            out_value <= tx_byte;
            out_last  <= (tx_phase == PH_CRC) && (crc_idx == 2'd3);
            if (tx_phase == PH_CRC) begin
              crc_idx <= crc_idx + 2'd1;
              if (crc_idx == 2'd3) begin
                state <= S_IDLE;
              end
            end else begin
              tx_crc <= tx_crc ^ {24'd0, tx_byte};
              state  <= S_TXCRC;
            end
          end
        end
        S_TXCRC: begin
          tx_crc  <= crc_step;
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            case (tx_phase)
              PH_LEN: begin
                tx_phase <= PH_CMD;
                state    <= S_TXBYTE;
              end
              PH_CMD: begin
                if (tx_plen == '0) begin
                  tx_phase <= PH_CRC;
                  state    <= S_TXBYTE;
                end else begin
                  tx_phase <= PH_PAY;
                  tx_ptr   <= '0;
                  state    <= S_TXRD;
                end
              end
              default: begin
                if (TCW'(tx_ptr) + TCW'(1) == tx_plen) begin
                  tx_phase <= PH_CRC;
                  state    <= S_TXBYTE;
                end else begin
                  tx_ptr <= tx_ptr + TAW'(1);
                  state  <= S_TXRD;
                end
              end
            endcase
          end
        end
        S_TXRD: begin
          state <= S_TXBYTE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_rx_count_range: assert property (@(posedge clk) disable iff (rst)
    rx_count <= CW'(FRAME_MAX))
    else $error("receive count beyond the longest frame");

  a_no_gather_while_waiting: assert property (@(posedge clk) disable iff (rst)
    awaiting_ack |-> (tx_count == '0))
    else $error("payload gathered while an ACK is outstanding");

  a_bit_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    ((state != S_RXCRC) && (state != S_TXCRC)) |-> (bit_cnt == '0))
    else $error("CRC bit counter left mid-byte");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_beat.ready) |=>
      (out_valid && $stable({out_kind, out_value, out_last})))
    else $error("output beat changed while stalled");
`endif

endmodule
